/* hdl/rvenc_pkg.sv */
// ----------------------------------------------------------------------------
// RV32IM encoder package
// Types, opcode constants and the mnemonic table shared by the encoder files.
// ----------------------------------------------------------------------------
package rvenc_pkg;

  // Major opcodes.
  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_NONE   = 7'b0000000;

  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_R    = 3'd1,
    FMT_I    = 3'd2,
    FMT_S    = 3'd3,
    FMT_B    = 3'd4,
    FMT_J    = 3'd5,
    FMT_U    = 3'd6
  } fmt_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_ALIGN = 2'd2
  } err_code_t;

  typedef struct packed {
    fmt_t       fmt;
    logic [6:0] opcode;
    logic [2:0] funct3;
    logic [6:0] funct7;
  } enc_row_t;

  typedef struct packed {
    logic [30:0]        pc;
    logic [30:0]        label_address;
    logic               use_label;
    logic signed [31:0] immediate;
    logic [4:0]         src2_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         dest_reg;
    logic [4:0]         action;
  } instr_t;

  typedef struct packed {
    err_code_t   error_code;
    logic [31:0] instr_word;
  } result_t;

  // One row per mnemonic index; the last three indices form nothing.
  localparam enc_row_t ENC_TABLE [32] = '{
    '{FMT_R, OP_R, 3'd0, F7_BASE},       // add
    '{FMT_R, OP_R, 3'd0, F7_ALT},        // sub
    '{FMT_R, OP_R, 3'd4, F7_BASE},       // xor
    '{FMT_R, OP_R, 3'd6, F7_BASE},       // or
    '{FMT_R, OP_R, 3'd7, F7_BASE},       // and
    '{FMT_R, OP_R, 3'd1, F7_BASE},       // sll
    '{FMT_R, OP_R, 3'd5, F7_BASE},       // srl
    '{FMT_R, OP_R, 3'd5, F7_ALT},        // sra
    '{FMT_R, OP_R, 3'd2, F7_BASE},       // slt
    '{FMT_R, OP_R, 3'd3, F7_BASE},       // sltu
    '{FMT_I, OP_IMM, 3'd0, F7_BASE},     // addi
    '{FMT_I, OP_LOAD, 3'd1, F7_BASE},    // lh
    '{FMT_I, OP_LOAD, 3'd2, F7_BASE},    // lw
    '{FMT_S, OP_STORE, 3'd1, F7_BASE},   // sh
    '{FMT_S, OP_STORE, 3'd2, F7_BASE},   // sw
    '{FMT_B, OP_BRANCH, 3'd0, F7_BASE},  // beq
    '{FMT_B, OP_BRANCH, 3'd1, F7_BASE},  // bne
    '{FMT_B, OP_BRANCH, 3'd4, F7_BASE},  // blt
    '{FMT_B, OP_BRANCH, 3'd5, F7_BASE},  // bge
    '{FMT_B, OP_BRANCH, 3'd6, F7_BASE},  // bltu
    '{FMT_B, OP_BRANCH, 3'd7, F7_BASE},  // bgeu
    '{FMT_J, OP_JAL, 3'd0, F7_BASE},     // jal
    '{FMT_I, OP_JALR, 3'd0, F7_BASE},    // jalr
    '{FMT_U, OP_LUI, 3'd0, F7_BASE},     // lui
    '{FMT_U, OP_AUIPC, 3'd0, F7_BASE},   // auipc
    '{FMT_R, OP_R, 3'd0, F7_MULDIV},     // mul
    '{FMT_R, OP_R, 3'd1, F7_MULDIV},     // mulh
    '{FMT_R, OP_R, 3'd4, F7_MULDIV},     // div
    '{FMT_R, OP_R, 3'd6, F7_MULDIV},     // rem
    '{FMT_NONE, OP_NONE, 3'd0, F7_BASE},
    '{FMT_NONE, OP_NONE, 3'd0, F7_BASE},
    '{FMT_NONE, OP_NONE, 3'd0, F7_BASE}
  };

endpackage

/* hdl/riscv_instruction_encoder_top.sv */
// ----------------------------------------------------------------------------
// RV32IM instruction encoder, top level
// Channel  Dir  Signals                        Carries
// s_       in   s_tvalid s_tready s_tdata      one decoded instruction
//                s_tuser                        (use_label flag in s_tuser)
// m_       out  m_tvalid m_tready m_tdata      machine word and error code
//
// One request is taken every cycle while the output is not stalled. A request
// is captured in the input register stage, passes the encoder logic and is
// offered from the output register stage: one register stage on the input and
// one on the output. rst clears both valid flags. When the output is stalled
// the input register holds, and s_tready drops only once both stages are full.
// ----------------------------------------------------------------------------
module riscv_instruction_encoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // action[4:0], dest_reg[9:5], src1_reg[14:10], src2_reg[19:15],
  // immediate[51:20], label_address[82:52], pc[113:83], zero pad[119:114]
  input  logic [rvenc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // use_label[0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // instr_word[31:0], error_code[33:32], zero pad[39:34]
  output logic [rvenc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  rvenc_pkg::instr_t  in_item;
  rvenc_pkg::instr_t  in_item_next;
  rvenc_pkg::result_t out_res;
  rvenc_pkg::result_t core_res;
  logic               in_valid;
  logic               out_valid;
  logic               advance;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_comb begin
    in_item_next.action        = s_tdata[4:0];
    in_item_next.dest_reg      = s_tdata[9:5];
    in_item_next.src1_reg      = s_tdata[14:10];
    in_item_next.src2_reg      = s_tdata[19:15];
    in_item_next.immediate     = s_tdata[51:20];
    in_item_next.label_address = s_tdata[82:52];
    in_item_next.pc            = s_tdata[113:83];
    in_item_next.use_label     = s_tuser;
  end

  rvenc_core u_core (
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= in_item_next;
    end
    if (advance && in_valid) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_res.error_code, out_res.instr_word};

  // A rejected instruction never carries a word.
  a_err_zero_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.error_code != rvenc_pkg::ERR_NONE) |->
      (out_res.instr_word == '0))
    else $error("error result carries a non-zero word");

  a_err_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.error_code == rvenc_pkg::ERR_NONE ||
                   out_res.error_code == rvenc_pkg::ERR_RANGE ||
                   out_res.error_code == rvenc_pkg::ERR_ALIGN))
    else $error("illegal error code on output");

  // A held input request must not be lost while the output is stalled.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("input stage dropped or changed a held request");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !in_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("ready low without both stages full");

endmodule

/* hdl/rvenc_core.sv */
// ----------------------------------------------------------------------------
// RV32IM encoder core
// Combinational formatting of one decoded instruction into its machine word,
// with the per-format immediate checks.
// ----------------------------------------------------------------------------
module rvenc_core (
  input  rvenc_pkg::instr_t  item,
  output rvenc_pkg::result_t res
);

  rvenc_pkg::enc_row_t row;
  logic [31:0] offset;
  logic [31:0] u;
  logic        is_bj;
  logic        fits_12;
  logic        fits_13;
  logic        fits_21;
  logic        fits_u20;

  assign row = rvenc_pkg::ENC_TABLE[item.action];
  assign is_bj = (row.fmt == rvenc_pkg::FMT_B) || (row.fmt == rvenc_pkg::FMT_J);

  // Both addresses are below 2^31, so the difference always fits in 32 bits.
  assign offset = {1'b0, item.label_address} - {1'b0, item.pc};
  assign u = (is_bj && item.use_label) ? offset : item.immediate;

  // A value fits a signed field when the field's sign bit and all bits above it agree.
  assign fits_12  = (&u[31:11]) || !(|u[31:11]);
  assign fits_13  = (&u[31:12]) || !(|u[31:12]);
  assign fits_21  = (&u[31:20]) || !(|u[31:20]);
  assign fits_u20 = !(|u[31:20]);

  always_comb begin
    res.instr_word = '0;
    res.error_code = rvenc_pkg::ERR_NONE;
    case (row.fmt)
      rvenc_pkg::FMT_R: begin
        res.instr_word = {row.funct7, item.src2_reg, item.src1_reg, row.funct3,
                          item.dest_reg, row.opcode};
      end
      rvenc_pkg::FMT_I: begin
        if (!fits_12) begin
          res.error_code = rvenc_pkg::ERR_RANGE;
        end else begin
          res.instr_word = {u[11:0], item.src1_reg, row.funct3, item.dest_reg,
                            row.opcode};
        end
      end
      rvenc_pkg::FMT_S: begin
        if (!fits_12) begin
          res.error_code = rvenc_pkg::ERR_RANGE;
        end else begin
          res.instr_word = {u[11:5], item.src2_reg, item.src1_reg, row.funct3,
                            u[4:0], row.opcode};
        end
      end
      rvenc_pkg::FMT_B: begin
        // Alignment is reported ahead of range.
        if (u[0]) begin
          res.error_code = rvenc_pkg::ERR_ALIGN;
        end else if (!fits_13) begin
          res.error_code = rvenc_pkg::ERR_RANGE;
        end else begin
          res.instr_word = {u[12], u[10:5], item.src2_reg, item.src1_reg,
                            row.funct3, u[4:1], u[11], row.opcode};
        end
      end
      rvenc_pkg::FMT_J: begin
        if (u[0]) begin
          res.error_code = rvenc_pkg::ERR_ALIGN;
        end else if (!fits_21) begin
          res.error_code = rvenc_pkg::ERR_RANGE;
        end else begin
          res.instr_word = {u[20], u[10:1], u[11], u[19:12], item.dest_reg,
                            row.opcode};
        end
      end
      rvenc_pkg::FMT_U: begin
        if (!fits_u20) begin
          res.error_code = rvenc_pkg::ERR_RANGE;
        end else begin
          res.instr_word = {u[19:0], item.dest_reg, row.opcode};
        end
      end
      default: begin
        res.instr_word = '0;
      end
    endcase
  end

endmodule

/* sim/tb_riscv_instruction_encoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the RV32IM instruction encoder
// Streams decoded instructions into the encoder and checks each machine word
// and error code against an encoding computed here, with random stalls on
// both the request and the result side.
// ----------------------------------------------------------------------------
module tb_riscv_instruction_encoder_top;

  typedef enum logic [4:0] {
    MN_ADD, MN_SUB, MN_XOR, MN_OR, MN_AND, MN_SLL, MN_SRL, MN_SRA, MN_SLT, MN_SLTU,
    MN_ADDI, MN_LH, MN_LW, MN_SH, MN_SW,
    MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
    MN_JAL, MN_JALR, MN_LUI, MN_AUIPC,
    MN_MUL, MN_MULH, MN_DIV, MN_REM,
    MN_RSVD0, MN_RSVD1, MN_RSVD2
  } mnemonic_t;

  localparam int RANDOM_REQS = 1100;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;

  rvenc_pkg::instr_t  pending_reqs [$];
  rvenc_pkg::result_t words_due [$];
  rvenc_pkg::instr_t  on_bus;
  int      total_reqs = 0;
  int      accepted = 0;
  int      mismatches = 0;
  int      cycle_no = 0;

  riscv_instruction_encoder_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic rvenc_pkg::fmt_t format_of(input logic [4:0] action);
    case (mnemonic_t'(action))
      MN_ADDI, MN_LH, MN_LW, MN_JALR:                   return rvenc_pkg::FMT_I;
      MN_SH, MN_SW:                                     return rvenc_pkg::FMT_S;
      MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU: return rvenc_pkg::FMT_B;
      MN_JAL:                                           return rvenc_pkg::FMT_J;
      MN_LUI, MN_AUIPC:                                 return rvenc_pkg::FMT_U;
      MN_RSVD0, MN_RSVD1, MN_RSVD2:                     return rvenc_pkg::FMT_NONE;
      default:                                          return rvenc_pkg::FMT_R;
    endcase
  endfunction

  function automatic void imm_bounds(input rvenc_pkg::fmt_t f, output int lo,
                                     output int hi);
    case (f)
      rvenc_pkg::FMT_I, rvenc_pkg::FMT_S: begin lo = -2048;    hi = 2047;    end
      rvenc_pkg::FMT_B:                   begin lo = -4096;    hi = 4094;    end
      rvenc_pkg::FMT_J:                   begin lo = -1048576; hi = 1048574; end
      rvenc_pkg::FMT_U:                   begin lo = 0;        hi = 1048575; end
      default:                            begin lo = 0;        hi = -1;      end
    endcase
  endfunction

  function automatic rvenc_pkg::result_t encode_instruction(input rvenc_pkg::instr_t r);
    rvenc_pkg::result_t res;
    rvenc_pkg::fmt_t    fmt;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    longint      off;
    logic [31:0] u;
    fmt = format_of(r.action);
    opc = rvenc_pkg::OP_R;
    f3  = 3'd0;
    f7  = rvenc_pkg::F7_BASE;
    case (mnemonic_t'(r.action))
      MN_SUB:   f7 = rvenc_pkg::F7_ALT;
      MN_XOR:   f3 = 3'd4;
      MN_OR:    f3 = 3'd6;
      MN_AND:   f3 = 3'd7;
      MN_SLL:   f3 = 3'd1;
      MN_SRL:   f3 = 3'd5;
      MN_SRA:   begin f3 = 3'd5; f7 = rvenc_pkg::F7_ALT; end
      MN_SLT:   f3 = 3'd2;
      MN_SLTU:  f3 = 3'd3;
      MN_ADDI:  opc = rvenc_pkg::OP_IMM;
      MN_LH:    begin opc = rvenc_pkg::OP_LOAD; f3 = 3'd1; end
      MN_LW:    begin opc = rvenc_pkg::OP_LOAD; f3 = 3'd2; end
      MN_SH:    begin opc = rvenc_pkg::OP_STORE; f3 = 3'd1; end
      MN_SW:    begin opc = rvenc_pkg::OP_STORE; f3 = 3'd2; end
      MN_BEQ:   opc = rvenc_pkg::OP_BRANCH;
      MN_BNE:   begin opc = rvenc_pkg::OP_BRANCH; f3 = 3'd1; end
      MN_BLT:   begin opc = rvenc_pkg::OP_BRANCH; f3 = 3'd4; end
      MN_BGE:   begin opc = rvenc_pkg::OP_BRANCH; f3 = 3'd5; end
      MN_BLTU:  begin opc = rvenc_pkg::OP_BRANCH; f3 = 3'd6; end
      MN_BGEU:  begin opc = rvenc_pkg::OP_BRANCH; f3 = 3'd7; end
      MN_JAL:   opc = rvenc_pkg::OP_JAL;
      MN_JALR:  opc = rvenc_pkg::OP_JALR;
      MN_LUI:   opc = rvenc_pkg::OP_LUI;
      MN_AUIPC: opc = rvenc_pkg::OP_AUIPC;
      MN_MUL:   f7 = rvenc_pkg::F7_MULDIV;
      MN_MULH:  begin f3 = 3'd1; f7 = rvenc_pkg::F7_MULDIV; end
      MN_DIV:   begin f3 = 3'd4; f7 = rvenc_pkg::F7_MULDIV; end
      MN_REM:   begin f3 = 3'd6; f7 = rvenc_pkg::F7_MULDIV; end
      default:  ;
    endcase

    // Branches and jal with a label take the distance from this instruction.
    off = longint'(signed'(r.immediate));
    if ((fmt == rvenc_pkg::FMT_B || fmt == rvenc_pkg::FMT_J) && r.use_label)
      off = longint'({33'd0, r.label_address}) - longint'({33'd0, r.pc});
    u = off[31:0];

    res.instr_word = '0;
    res.error_code = rvenc_pkg::ERR_NONE;
    case (fmt)
      rvenc_pkg::FMT_R:
        res.instr_word = {f7, r.src2_reg, r.src1_reg, f3, r.dest_reg, opc};
      rvenc_pkg::FMT_I:
        if (off < -2048 || off > 2047) res.error_code = rvenc_pkg::ERR_RANGE;
        else res.instr_word = {u[11:0], r.src1_reg, f3, r.dest_reg, opc};
      rvenc_pkg::FMT_S:
        if (off < -2048 || off > 2047) res.error_code = rvenc_pkg::ERR_RANGE;
        else res.instr_word = {u[11:5], r.src2_reg, r.src1_reg, f3, u[4:0], opc};
      rvenc_pkg::FMT_B:
        if (u[0]) res.error_code = rvenc_pkg::ERR_ALIGN;
        else if (off < -4096 || off > 4094) res.error_code = rvenc_pkg::ERR_RANGE;
        else res.instr_word = {u[12], u[10:5], r.src2_reg, r.src1_reg, f3,
                               u[4:1], u[11], opc};
      rvenc_pkg::FMT_J:
        if (u[0]) res.error_code = rvenc_pkg::ERR_ALIGN;
        else if (off < -1048576 || off > 1048574) res.error_code = rvenc_pkg::ERR_RANGE;
        else res.instr_word = {u[20], u[10:1], u[11], u[19:12], r.dest_reg, opc};
      rvenc_pkg::FMT_U:
        if (off < 0 || off > 1048575) res.error_code = rvenc_pkg::ERR_RANGE;
        else res.instr_word = {u[19:0], r.dest_reg, opc};
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_req(input mnemonic_t mn, input logic [4:0] rd, input logic [4:0] rs1,
                           input logic [4:0] rs2, input int imm, input logic lbl,
                           input logic [30:0] label, input logic [30:0] pc);
    rvenc_pkg::instr_t r;
    r.action        = mn;
    r.dest_reg      = rd;
    r.src1_reg      = rs1;
    r.src2_reg      = rs2;
    r.immediate     = imm;
    r.use_label     = lbl;
    r.label_address = label;
    r.pc            = pc;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Outside the quiet stretch, each side takes a break with a chance of 30 in 100.
  function automatic bit take_break();
    if ((cycle_no % 1500) >= 1000) return 1'b0;
    return $urandom_range(99) < 30;
  endfunction

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        words_due.insert(words_due.size(), encode_instruction(on_bus));
        accepted = accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && !take_break()) begin
          on_bus = pending_reqs.pop_front();
          s_tdata  <= {6'd0, on_bus.pc, on_bus.label_address, on_bus.immediate,
                       on_bus.src2_reg, on_bus.src1_reg, on_bus.dest_reg, on_bus.action};
          s_tuser  <= on_bus.use_label;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    rvenc_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (words_due.size() == 0) begin
          mismatches = mismatches + 1;
          $error("result %h arrived with no request outstanding", m_tdata);
        end else begin
          want = words_due.pop_front();
          if (m_tdata[31:0] !== want.instr_word) begin
            mismatches = mismatches + 1;
            $error("instr_word: expected %h, got %h", want.instr_word, m_tdata[31:0]);
          end
          if (m_tdata[33:32] !== want.error_code) begin
            mismatches = mismatches + 1;
            $error("error_code: expected %0d, got %0d", want.error_code, m_tdata[33:32]);
          end
        end
      end
      m_tready <= !take_break();
    end
  end

  initial begin : stimulus
    int              lo, hi, off, pick;
    rvenc_pkg::fmt_t f;
    mnemonic_t       mn;
    logic [30:0]     pc;

    // Every mnemonic, including the unused ones, at the top of its range.
    for (int a = 0; a < 32; a++) begin
      mn = mnemonic_t'(a);
      imm_bounds(format_of(mn), lo, hi);
      if (a % 2) queue_req(mn, 5'd31, 5'd0, 5'd31, hi, 1'b0, '0, '0);
      else       queue_req(mn, 5'd0, 5'd31, 5'd0, hi, 1'b0, 31'h7fffffff, 31'h7fffffff);
    end
    // Range edges and the special cases of each format.
    queue_req(MN_ADDI, 5'd1, 5'd2, 5'd3, -2048, 1'b0, '0, '0);
    queue_req(MN_ADDI, 5'd1, 5'd2, 5'd3, -2049, 1'b0, '0, '0);
    queue_req(MN_LH, 5'd1, 5'd2, 5'd3, 2048, 1'b0, '0, '0);
    queue_req(MN_ADDI, 5'd5, 5'd6, 5'd7, 32'h80000000, 1'b0, '0, '0);
    queue_req(MN_JALR, 5'd31, 5'd31, 5'd31, 32'h7fffffff, 1'b0, '0, '0);
    // A label on a mnemonic that is not a branch or jal changes nothing.
    queue_req(MN_LW, 5'd9, 5'd10, 5'd11, -1, 1'b1, 31'h7fffffff, 31'd0);
    queue_req(MN_SH, 5'd4, 5'd8, 5'd12, -2048, 1'b0, '0, '0);
    queue_req(MN_SW, 5'd4, 5'd8, 5'd12, 2048, 1'b0, '0, '0);
    queue_req(MN_BEQ, 5'd0, 5'd1, 5'd2, -4096, 1'b0, '0, '0);
    queue_req(MN_BNE, 5'd0, 5'd1, 5'd2, -4098, 1'b0, '0, '0);
    queue_req(MN_BLT, 5'd0, 5'd1, 5'd2, 4096, 1'b0, '0, '0);
    // An odd offset is reported as misaligned even when it is also too far.
    queue_req(MN_BGE, 5'd0, 5'd1, 5'd2, 5001, 1'b0, '0, '0);
    queue_req(MN_BLTU, 5'd0, 5'd1, 5'd2, -1, 1'b0, '0, '0);
    queue_req(MN_BGEU, 5'd0, 5'd3, 5'd4, 0, 1'b1, 31'd14094, 31'd10000);
    queue_req(MN_BEQ, 5'd0, 5'd3, 5'd4, 0, 1'b1, 31'd5904, 31'd10000);
    queue_req(MN_BNE, 5'd0, 5'd3, 5'd4, 0, 1'b1, 31'd10001, 31'd10000);
    queue_req(MN_BLT, 5'd0, 5'd3, 5'd4, 0, 1'b1, 31'd0, 31'h7ffffffe);
    queue_req(MN_JAL, 5'd17, 5'd0, 5'd0, -1048576, 1'b0, '0, '0);
    queue_req(MN_JAL, 5'd17, 5'd0, 5'd0, 1048576, 1'b0, '0, '0);
    queue_req(MN_JAL, 5'd17, 5'd0, 5'd0, 1048577, 1'b0, '0, '0);
    queue_req(MN_JAL, 5'd1, 5'd0, 5'd0, 3, 1'b1, 31'd1048674, 31'd100);
    queue_req(MN_JAL, 5'd1, 5'd0, 5'd0, 0, 1'b1, 31'h7ffffffe, 31'd0);
    queue_req(MN_LUI, 5'd2, 5'd0, 5'd0, 0, 1'b0, '0, '0);
    queue_req(MN_LUI, 5'd2, 5'd0, 5'd0, -1, 1'b0, '0, '0);
    queue_req(MN_AUIPC, 5'd2, 5'd0, 5'd0, 1048576, 1'b0, '0, '0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(9) == 0) mn = mnemonic_t'($urandom_range(31));
      else                        mn = mnemonic_t'($urandom_range(28));
      f = format_of(mn);
      imm_bounds(f, lo, hi);
      pick = $urandom_range(9);
      // Mostly offsets that fit the format, then edges, small values and noise.
      if (pick < 5 && f != rvenc_pkg::FMT_R && f != rvenc_pkg::FMT_NONE) begin
        case (f)
          rvenc_pkg::FMT_B: off = (int'($urandom_range(4095)) - 2048) * 2;
          rvenc_pkg::FMT_J: off = (int'($urandom_range(1048575)) - 524288) * 2;
          default:          off = lo + int'($urandom_range(hi - lo));
        endcase
      end else if (pick < 6) begin
        case ($urandom_range(3))
          0:       off = lo;
          1:       off = lo - 1;
          2:       off = hi;
          default: off = hi + 1;
        endcase
      end else if (pick < 7) begin
        off = int'($urandom_range(64)) - 32;
      end else begin
        off = $urandom;
      end
      pc = 31'($urandom);
      if ($urandom_range(1)) begin
        if ($urandom_range(9) < 8)
          queue_req(mn, 5'($urandom), 5'($urandom), 5'($urandom), $urandom,
                    1'b1, 31'(pc + off), pc);
        else
          queue_req(mn, 5'($urandom), 5'($urandom), 5'($urandom), $urandom,
                    1'b1, 31'($urandom), pc);
      end else begin
        queue_req(mn, 5'($urandom), 5'($urandom), 5'($urandom), off, 1'b0,
                  31'($urandom), pc);
      end
    end
    total_reqs = pending_reqs.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted < total_reqs || words_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("riscv_instruction_encoder_top: match");
    else
      $display("riscv_instruction_encoder_top: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("riscv_instruction_encoder_top: mismatch");
    $finish;
  end

endmodule
